FILE: sv/pit_pkg.sv
// Shared types, codes and a helper function of the phased interval timer.
`timescale 1ns / 1ps

package pit_pkg;

   localparam int DELTA_W = 16;
   localparam int MS_W    = 26;
   localparam int SECS_W  = 16;
   localparam int SESS_W  = 16;
   localparam int POS_W   = 8;
   localparam int PROG_W  = 16;
   localparam int DIV_CNT_W = $clog2(PROG_W);

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STOP  = 2'd2;

   localparam logic [1:0] CSR_WORK_SECONDS  = 2'd0;
   localparam logic [1:0] CSR_SHORT_SECONDS = 2'd1;
   localparam logic [1:0] CSR_LONG_SECONDS  = 2'd2;
   localparam logic [1:0] CSR_LONG_PERIOD   = 2'd3;

   localparam logic [SECS_W-1:0] WORK_SECONDS_RESET  = 16'd1500;
   localparam logic [SECS_W-1:0] SHORT_SECONDS_RESET = 16'd300;
   localparam logic [SECS_W-1:0] LONG_SECONDS_RESET  = 16'd900;
   localparam logic [POS_W-1:0]  LONG_PERIOD_RESET   = 8'd4;

   typedef enum logic [1:0] {
      PH_WORK  = 2'd0,
      PH_SHORT = 2'd1,
      PH_LONG  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [DELTA_W-1:0] delta_ms;
   } req_type_s_type;

   typedef struct packed {
      phase_type          phase_now;
      logic [MS_W-1:0]    remaining_ms;
      logic [SESS_W-1:0]  sessions_done;
      logic               is_running;
      logic [PROG_W-1:0]  progress_q16;
   } rsp_data_type;

   typedef struct packed {
      logic take_req;
      logic loop_step;
      logic div_init;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic tick_go;
      logic delta_zero;
      logic rsp_free;
   } status_type;

   // Seconds to milliseconds by shift and subtract; a zero length counts as one second.
   function automatic logic [MS_W-1:0] secs_to_ms(input logic [SECS_W-1:0] secs);
      logic [MS_W-1:0] v;
      v = (secs == '0) ? MS_W'(1) : MS_W'(secs);
      return (v << 10) - (v << 4) - (v << 3);
   endfunction

endpackage

FILE: sv/pit_ctrl.sv
// Sequencer of the phased interval timer: handshakes, phase loop and divide steps.
`timescale 1ns / 1ps

module pit_ctrl import pit_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (req_valid && !csr_valid) begin
               cmd.take_req = 1'b1;
               state_in     = status.tick_go ? ST_LOOP : ST_DONE;
            end
         end
         ST_LOOP: begin
            if (status.delta_zero) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               cmd.loop_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(PROG_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/pit_datapath.sv
// Timer state, configuration, phase advance, serial progress divider and result register.
`timescale 1ns / 1ps

module pit_datapath import pit_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  req_type_s_type req_data,
   input  logic           csr_write,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_data,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output rsp_data_type   rsp_data,
   input  cmd_type        cmd,
   output status_type     status
);

   logic [MS_W-1:0]    work_ms_ff, work_ms_in;
   logic [MS_W-1:0]    short_ms_ff, short_ms_in;
   logic [MS_W-1:0]    long_ms_ff, long_ms_in;
   logic [POS_W-1:0]   period_ff, period_in;

   logic               running_ff, running_in;
   phase_type          phase_ff, phase_in;
   logic [MS_W-1:0]    remaining_ff, remaining_in;
   logic [SESS_W-1:0]  sessions_ff, sessions_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PROG_W-1:0]  progress_ff, progress_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic [MS_W-1:0]    div_r_ff, div_r_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_ff, rsp_in;

   logic [MS_W-1:0]    cur_len;
   logic [MS_W-1:0]    new_ms;
   logic [MS_W-1:0]    delta_ext;
   logic [POS_W-1:0]   pos_next;
   logic [MS_W:0]      div_shift;
   logic               div_fit;

   function automatic logic [MS_W-1:0] len_of(input phase_type ph,
                                               input logic [MS_W-1:0] w,
                                               input logic [MS_W-1:0] s,
                                               input logic [MS_W-1:0] l);
      logic [MS_W-1:0] r;
      case (ph)
         PH_SHORT: r = s;
         PH_LONG:  r = l;
         default:  r = w;
      endcase
      return r;
   endfunction

   assign cur_len   = len_of(phase_ff, work_ms_ff, short_ms_ff, long_ms_ff);
   assign new_ms    = secs_to_ms(csr_data);
   assign delta_ext = MS_W'(delta_ff);
   assign pos_next  = pos_ff + 1'b1;
   assign div_shift = {div_r_ff, 1'b0};
   assign div_fit   = div_shift >= {1'b0, cur_len};

   assign status.tick_go    = (req_data.req_type == REQ_TICK) && running_ff;
   assign status.delta_zero = (delta_ff == '0);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ms_ff   <= secs_to_ms(WORK_SECONDS_RESET);
         short_ms_ff  <= secs_to_ms(SHORT_SECONDS_RESET);
         long_ms_ff   <= secs_to_ms(LONG_SECONDS_RESET);
         period_ff    <= LONG_PERIOD_RESET;
         running_ff   <= 1'b0;
         phase_ff     <= PH_WORK;
         remaining_ff <= secs_to_ms(WORK_SECONDS_RESET);
         sessions_ff  <= '0;
         pos_ff       <= '0;
         progress_ff  <= '0;
         delta_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         work_ms_ff   <= work_ms_in;
         short_ms_ff  <= short_ms_in;
         long_ms_ff   <= long_ms_in;
         period_ff    <= period_in;
         running_ff   <= running_in;
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         sessions_ff  <= sessions_in;
         pos_ff       <= pos_in;
         progress_ff  <= progress_in;
         delta_ff     <= delta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_r_ff <= div_r_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      work_ms_in   = work_ms_ff;
      short_ms_in  = short_ms_ff;
      long_ms_in   = long_ms_ff;
      period_in    = period_ff;
      running_in   = running_ff;
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      sessions_in  = sessions_ff;
      pos_in       = pos_ff;
      progress_in  = progress_ff;
      delta_in     = delta_ff;
      div_r_in     = div_r_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write) begin
         case (csr_index)
            CSR_WORK_SECONDS:  work_ms_in  = new_ms;
            CSR_SHORT_SECONDS: short_ms_in = new_ms;
            CSR_LONG_SECONDS:  long_ms_in  = new_ms;
            CSR_LONG_PERIOD:   period_in   = csr_data[POS_W-1:0];
            default:           period_in   = period_ff;
         endcase
         running_in   = 1'b0;
         phase_in     = PH_WORK;
         remaining_in = (csr_index == CSR_WORK_SECONDS) ? new_ms : work_ms_ff;
         sessions_in  = '0;
         pos_in       = '0;
         progress_in  = '0;
      end

      if (cmd.take_req) begin
         delta_in = req_data.delta_ms;
         case (req_data.req_type)
            REQ_START: running_in = 1'b1;
            REQ_STOP: begin
               running_in   = 1'b0;
               phase_in     = PH_WORK;
               remaining_in = work_ms_ff;
               sessions_in  = '0;
               pos_in       = '0;
               progress_in  = '0;
            end
            default: running_in = running_ff;
         endcase
      end

      if (cmd.loop_step) begin
         if (remaining_ff > delta_ext) begin
            remaining_in = remaining_ff - delta_ext;
            delta_in     = '0;
         end else begin
            delta_in = delta_ff - remaining_ff[DELTA_W-1:0];
            if (phase_ff == PH_WORK) begin
               sessions_in = sessions_ff + 1'b1;
               if (pos_next == period_ff) begin
                  pos_in       = '0;
                  phase_in     = PH_LONG;
                  remaining_in = long_ms_ff;
               end else begin
                  pos_in       = pos_next;
                  phase_in     = PH_SHORT;
                  remaining_in = short_ms_ff;
               end
            end else begin
               phase_in     = PH_WORK;
               remaining_in = work_ms_ff;
            end
         end
      end

      if (cmd.div_init) begin
         div_r_in    = cur_len - remaining_ff;
         progress_in = '0;
      end

      if (cmd.div_step) begin
         div_r_in    = div_fit ? MS_W'(div_shift - {1'b0, cur_len}) : div_shift[MS_W-1:0];
         progress_in = {progress_ff[PROG_W-2:0], div_fit};
      end

      if (cmd.load_rsp) begin
         rsp_in.phase_now     = phase_ff;
         rsp_in.remaining_ms  = remaining_ff;
         rsp_in.sessions_done = sessions_ff;
         rsp_in.is_running    = running_ff;
         rsp_in.progress_q16  = progress_ff;
         rsp_valid_in         = 1'b1;
      end
   end

endmodule

FILE: sv/phased_interval_timer_core.sv
// Top level of the phased interval timer: sequencer and datapath.
// Start, stop and unknown codes, and a tick while stopped, go from acceptance to the result
// register; a running tick first walks the phase loop, one pass per phase end it crosses
// and one more for any remainder left in the last phase, then runs a 16-step serial divide.
// One request beat is in flight at a time; the next is accepted as the last one completes.
// Synchronous active-high reset restores the default lengths and rewinds to a stopped work phase.
`timescale 1ns / 1ps

module phased_interval_timer_core import pit_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type_s_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_data_type   rsp_data,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [1:0]     csr_index,
   input  logic [15:0]    csr_data
);

   cmd_type    cmd;
   status_type status;

   pit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pit_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: sv/pit_checker.sv
// Port-level assertions of the phased interval timer and their binding to the top level.
`timescale 1ns / 1ps

module pit_checker import pit_pkg::*; (
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_ready,
   input logic           rsp_valid,
   input logic           rsp_ready,
   input rsp_data_type   rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is in progress");

   a_remaining_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.remaining_ms != '0)
      else $error("result shows an exhausted phase");

   a_stopped_rewound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_running |->
         rsp_data.phase_now == PH_WORK && rsp_data.sessions_done == '0 &&
         rsp_data.progress_q16 == '0)
      else $error("stopped timer is not at the start of work");

endmodule

bind phased_interval_timer_core pit_checker u_pit_checker (.*);

FILE: test/phased_interval_timer_core_tb.sv
// Self-checking testbench of the phased interval timer against a local mirror of the timer.
`timescale 1ns / 1ps

module phased_interval_timer_core_tb;
   import pit_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 120;
   localparam int CYCLE_LIMIT   = 4000000;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   req_type_s_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   rsp_data_type   rsp_data;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [1:0]     csr_index = '0;
   logic [15:0]    csr_data = '0;

   phased_interval_timer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Local copy of the timer's lengths and state.
   logic [15:0] len_work_s;
   logic [15:0] len_short_s;
   logic [15:0] len_long_s;
   logic [7:0]  long_every;
   logic        run_flag;
   phase_type   cur_phase;
   logic [25:0] left_ms;
   logic [15:0] sess_cnt;
   logic [7:0]  cyc_pos;
   logic [15:0] prog_val;

   rsp_data_type status_q[$];
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int items_sent = 0;
   int beats_seen = 0;
   int reg_writes = 0;
   int cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [25:0] phase_ms(input phase_type ph);
      logic [15:0] s;
      case (ph)
         PH_SHORT: s = len_short_s;
         PH_LONG:  s = len_long_s;
         default:  s = len_work_s;
      endcase
      if (s == 16'd0) s = 16'd1;
      return 26'(s * 26'd1000);
   endfunction

   function automatic void rewind_timer();
      run_flag  = 1'b0;
      cur_phase = PH_WORK;
      left_ms   = phase_ms(PH_WORK);
      sess_cnt  = '0;
      cyc_pos   = '0;
      prog_val  = '0;
   endfunction

   function automatic void next_phase();
      if (cur_phase == PH_WORK) begin
         sess_cnt = sess_cnt + 16'd1;
         cyc_pos  = cyc_pos + 8'd1;
         if (cyc_pos == long_every) begin
            cyc_pos   = '0;
            cur_phase = PH_LONG;
         end else begin
            cur_phase = PH_SHORT;
         end
      end else begin
         cur_phase = PH_WORK;
      end
      left_ms = phase_ms(cur_phase);
   endfunction

   function automatic void consume_ms(input logic [15:0] delta);
      logic [25:0] rest;
      logic [25:0] used;
      logic [25:0] dur;
      logic [63:0] quot;
      rest = 26'(delta);
      while (rest != 26'd0) begin
         used = (left_ms < rest) ? left_ms : rest;
         left_ms = left_ms - used;
         rest = rest - used;
         if (left_ms == 26'd0) next_phase();
      end
      dur = phase_ms(cur_phase);
      if (left_ms == 26'd0) begin
         prog_val = 16'hFFFF;
      end else if (left_ms >= dur) begin
         prog_val = '0;
      end else begin
         quot = (64'(dur - left_ms) << 16) / 64'(dur);
         prog_val = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
      end
   endfunction

   function automatic rsp_data_type apply_request(input logic [1:0] kind,
                                                  input logic [15:0] delta);
      rsp_data_type st;
      case (kind)
         REQ_TICK: begin
            if (run_flag) consume_ms(delta);
         end
         REQ_START: begin
            run_flag = 1'b1;
         end
         REQ_STOP: begin
            rewind_timer();
         end
         default: begin
         end
      endcase
      st.phase_now     = cur_phase;
      st.remaining_ms  = left_ms;
      st.sessions_done = sess_cnt;
      st.is_running    = run_flag;
      st.progress_q16  = prog_val;
      return st;
   endfunction

   function automatic void store_reg(input logic [1:0] idx, input logic [15:0] val);
      case (idx)
         CSR_WORK_SECONDS:  len_work_s  = val;
         CSR_SHORT_SECONDS: len_short_s = val;
         CSR_LONG_SECONDS:  len_long_s  = val;
         default:           long_every  = val[7:0];
      endcase
      rewind_timer();
   endfunction

   function automatic logic [15:0] pick_seconds();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 16'($urandom_range(1, 6));
      if (r < 88) return 16'($urandom_range(0, 40));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_period();
      if ($urandom_range(0, 99) < 80) return 16'($urandom_range(1, 4));
      return 16'($urandom);
   endfunction

   task automatic check_field(input string what, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (status_q.size() == 0) begin
            $display("%0t: status beat with nothing expected, actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            want = status_q.pop_front();
            check_field("phase_now", want.phase_now, rsp_data.phase_now);
            check_field("remaining_ms", want.remaining_ms, rsp_data.remaining_ms);
            check_field("sessions_done", want.sessions_done, rsp_data.sessions_done);
            check_field("is_running", want.is_running, rsp_data.is_running);
            check_field("progress_q16", want.progress_q16, rsp_data.progress_q16);
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_req(input logic [1:0] kind, input logic [15:0] delta);
      req_type_s_type beat;
      beat.req_type = kind;
      beat.delta_ms = delta;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      status_q.insert(status_q.size(), apply_request(kind, delta));
      items_sent++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      store_reg(idx, val);
      reg_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_all(input logic [15:0] work_s, input logic [15:0] short_s,
                            input logic [15:0] long_s, input logic [15:0] period);
      wait_idle();
      write_reg(CSR_WORK_SECONDS, work_s);
      write_reg(CSR_SHORT_SECONDS, short_s);
      write_reg(CSR_LONG_SECONDS, long_s);
      write_reg(CSR_LONG_PERIOD, period);
   endtask

   task automatic test_defaults();
      send_req(REQ_TICK, 16'hFFFF);
      send_req(REQ_UNUSED, 16'h0000);
      send_req(REQ_START, 16'h0000);
      send_req(REQ_START, 16'hFFFF);
      send_req(REQ_TICK, 16'd0);
      send_req(REQ_TICK, 16'd1);
      send_req(REQ_TICK, 16'hFFFF);
      send_req(REQ_STOP, 16'hFFFF);
   endtask

   task automatic test_phase_sequence();
      write_all(16'd1, 16'd2, 16'd3, 16'd2);
      send_req(REQ_START, 16'd0);
      send_req(REQ_TICK, 16'd1000);
      send_req(REQ_TICK, 16'd1999);
      send_req(REQ_TICK, 16'd1);
      send_req(REQ_TICK, 16'd1000);
      send_req(REQ_TICK, 16'd2500);
      send_req(REQ_TICK, 16'd500);
      send_req(REQ_STOP, 16'd0);
      send_req(REQ_TICK, 16'd500);
   endtask

   task automatic test_zero_lengths();
      int k;
      write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_req(REQ_START, 16'd0);
      for (k = 0; k < 8; k++) send_req(REQ_TICK, 16'hFFFF);
   endtask

   task automatic test_max_lengths();
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_req(REQ_START, 16'd0);
      send_req(REQ_TICK, 16'hFFFF);
      send_req(REQ_TICK, 16'd12345);
      send_req(REQ_STOP, 16'd0);
   endtask

   task automatic test_random(input int n, input int gap, input int stall);
      int k;
      int r;
      logic [1:0] kind;
      logic [15:0] delta;
      send_gap_pct = gap;
      recv_stall_pct = stall;
      for (k = 0; k < n; k++) begin
         if (k % 150 == 0) begin
            write_all(pick_seconds(), pick_seconds(), pick_seconds(), pick_period());
            send_req(REQ_START, 16'($urandom));
         end else if ($urandom_range(0, 199) == 0) begin
            wait_idle();
         end
         r = $urandom_range(0, 99);
         if (r < 72) kind = REQ_TICK;
         else if (r < 86) kind = REQ_START;
         else if (r < 94) kind = REQ_STOP;
         else kind = REQ_UNUSED;
         r = $urandom_range(0, 99);
         if (r < 50) delta = 16'($urandom_range(0, 3000));
         else if (r < 80) delta = 16'($urandom_range(0, 20000));
         else delta = 16'($urandom);
         send_req(kind, delta);
      end
   endtask

   initial begin
      len_work_s  = WORK_SECONDS_RESET;
      len_short_s = SHORT_SECONDS_RESET;
      len_long_s  = LONG_SECONDS_RESET;
      long_every  = LONG_PERIOD_RESET;
      rewind_timer();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 29;
      recv_stall_pct = 49;
      test_defaults();
      test_phase_sequence();
      test_zero_lengths();
      test_max_lengths();
      test_random(580, 29, 49);
      test_random(580, 49, 29);
      test_random(580, 0, 0);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d request beats, %0d status beats and %0d register writes,",
               items_sent, beats_seen, reg_writes);
      $display("including zero and full-scale lengths, unknown codes and three idling mixes.");
      if (fail_count == 0 && status_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
